>>> rtl/vec4_reflect_about_normal_core_defines.svh
// assertion macros used by the bound checker in v4rn_checker.sv
`ifndef VEC4_REFLECT_ABOUT_NORMAL_CORE_DEFINES_SVH
`define VEC4_REFLECT_ABOUT_NORMAL_CORE_DEFINES_SVH

// implication checked at every clock edge outside reset
`define V4RN_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition that holds at every clock edge outside reset
`define V4RN_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

`endif

>>> rtl/v4rn_pkg.sv
package v4rn_pkg;

  // default component format, signed Q4.12
  localparam int COMP_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 12;

  // threshold register
  localparam int             CFG_W     = 15;
  localparam logic [CFG_W-1:0] CFG_RESET = 15'd1;

  // clock edges from an accepted start to the accepting edge of its result
  function automatic int latency(input int comp_width, input int frac_bits);
    latency = comp_width + frac_bits + 13;
  endfunction

endpackage

>>> rtl/vec4_reflect_about_normal_core.sv
// channel   | ports                               | transfer
// ----------+-------------------------------------+------------------------------
// input     | start, busy, in_vec_*, in_nrm_*     | edge with start high, busy low
// result    | out_valid, out_refl_*, out_short_*, | one cycle with out_valid high
//           | out_clipped                         |
// config    | cfg_we, cfg_data                    | edge with cfg_we high
//
// one item per cycle (Q4.12 components by default); the pipeline depth comes
// mostly from the bit-per-stage square root (COMP_WIDTH+1 stages) and the
// bit-per-stage reciprocal divide (FRAC_BITS+2 stages).
// busy is always low; the pipeline moves every cycle and never stalls.
// synchronous reset clears the valid bits and sets the threshold to 1.
module vec4_reflect_about_normal_core #(
  parameter int COMP_WIDTH = v4rn_pkg::COMP_WIDTH_DEF,
  parameter int FRAC_BITS  = v4rn_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COMP_WIDTH-1:0] in_vec_x,
  input  logic signed [COMP_WIDTH-1:0] in_vec_y,
  input  logic signed [COMP_WIDTH-1:0] in_vec_z,
  input  logic signed [COMP_WIDTH-1:0] in_vec_w,
  input  logic signed [COMP_WIDTH-1:0] in_nrm_x,
  input  logic signed [COMP_WIDTH-1:0] in_nrm_y,
  input  logic signed [COMP_WIDTH-1:0] in_nrm_z,
  input  logic signed [COMP_WIDTH-1:0] in_nrm_w,
  output logic                         out_valid,
  output logic signed [COMP_WIDTH-1:0] out_refl_x,
  output logic signed [COMP_WIDTH-1:0] out_refl_y,
  output logic signed [COMP_WIDTH-1:0] out_refl_z,
  output logic signed [COMP_WIDTH-1:0] out_refl_w,
  output logic                         out_short_normal,
  output logic                         out_clipped,
  input  logic                         cfg_we,
  input  logic [v4rn_pkg::CFG_W-1:0]   cfg_data
);

  localparam int W    = COMP_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int LW   = v4rn_pkg::CFG_W;
  localparam int SW   = 2 * W + 1;
  localparam int RB   = W + 1;
  localparam int QB   = F + 2;
  localparam int DW   = W + F + 3;
  localparam int UW   = ((W > F + 2) ? W : F + 2) + 1;
  localparam int PRW  = W + UW;
  localparam int PW   = PRW + 2;
  localparam int CW   = W + F + 3;
  localparam int MW   = CW + UW;
  localparam int CMPW = (SW > 2 * LW) ? SW : 2 * LW;

  localparam logic signed [MW:0] RMAX = {{(MW - W + 2){1'b0}}, {(W - 1){1'b1}}};
  localparam logic signed [MW:0] RMIN = -RMAX - 1;

  // data that rides along the pipeline
  typedef struct packed {
    logic [3:0][W-1:0] a;
    logic [3:0][W-1:0] nm;
    logic [3:0]        ng;
    logic              lng;
  } side_t;

  // threshold register
  logic [LW-1:0] min_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= v4rn_pkg::CFG_RESET;
    end else if (cfg_we) begin
      min_len_r <= cfg_data;
    end
  end

  assign busy = 1'b0;

  // stage a: input capture
  logic              a_v_r;
  logic [3:0][W-1:0] a_vec_r;
  logic [3:0][W-1:0] a_nrm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else begin
      a_v_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    a_vec_r[0] <= in_vec_x;
    a_vec_r[1] <= in_vec_y;
    a_vec_r[2] <= in_vec_z;
    a_vec_r[3] <= in_vec_w;
    a_nrm_r[0] <= in_nrm_x;
    a_nrm_r[1] <= in_nrm_y;
    a_nrm_r[2] <= in_nrm_z;
    a_nrm_r[3] <= in_nrm_w;
  end

  // stage b: magnitudes, squares and squared threshold
  logic                b_v_r;
  side_t               b_sd_r;
  logic [3:0][2*W-1:0] b_sq_r;
  logic [2*LW-1:0]     b_thr_r;
  logic [3:0][W-1:0]   b_nm;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      b_nm[i] = a_nrm_r[i][W-1] ? (~a_nrm_r[i] + W'(1)) : a_nrm_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      b_sq_r[i]    <= (2 * W)'(b_nm[i]) * (2 * W)'(b_nm[i]);
      b_sd_r.ng[i] <= a_nrm_r[i][W-1];
    end
    b_sd_r.a   <= a_vec_r;
    b_sd_r.nm  <= b_nm;
    b_sd_r.lng <= 1'b0;
    b_thr_r    <= (2 * LW)'(min_len_r) * (2 * LW)'(min_len_r);
  end

  // stage c: sum of squares and threshold test, feeds the square root
  logic          sq_v_r   [RB+1];
  logic [SW-1:0] sq_rem_r [RB+1];
  logic [RB-1:0] sq_res_r [RB+1];
  side_t         sq_sd_r  [RB+1];
  logic [SW-1:0] c_sum;

  always_comb begin
    c_sum = '0;
    for (int i = 0; i < 4; i++) begin
      c_sum = c_sum + SW'(b_sq_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else begin
      sq_v_r[0] <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    sq_rem_r[0]    <= c_sum;
    sq_res_r[0]    <= '0;
    sq_sd_r[0].a   <= b_sd_r.a;
    sq_sd_r[0].nm  <= b_sd_r.nm;
    sq_sd_r[0].ng  <= b_sd_r.ng;
    sq_sd_r[0].lng <= CMPW'(c_sum) > CMPW'(b_thr_r);
  end

  // square root, one result bit per stage
  for (genvar j = 0; j < RB; j++) begin : g_sqrt
    localparam int K = RB - 1 - j;
    logic [SW-1:0] trial;

    assign trial = (SW'(sq_res_r[j]) << (K + 1)) + (SW'(1) << (2 * K));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[j+1] <= 1'b0;
      end else begin
        sq_v_r[j+1] <= sq_v_r[j];
      end
    end

    always_ff @(posedge clk) begin
      sq_sd_r[j+1] <= sq_sd_r[j];
      if (sq_rem_r[j] >= trial) begin
        sq_rem_r[j+1] <= sq_rem_r[j] - trial;
        sq_res_r[j+1] <= sq_res_r[j] | (RB'(1) << K);
      end else begin
        sq_rem_r[j+1] <= sq_rem_r[j];
        sq_res_r[j+1] <= sq_res_r[j];
      end
    end
  end

  // round the magnitude to nearest
  logic          rd_v_r;
  logic [RB-1:0] rd_m_r;
  side_t         rd_sd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
    end else begin
      rd_v_r <= sq_v_r[RB];
    end
  end

  always_ff @(posedge clk) begin
    rd_sd_r <= sq_sd_r[RB];
    if (sq_rem_r[RB] > SW'(sq_res_r[RB])) begin
      rd_m_r <= sq_res_r[RB] + RB'(1);
    end else begin
      rd_m_r <= sq_res_r[RB];
    end
  end

  // numerators of the reciprocal divide, feed the divider
  logic                 dv_v_r   [QB+1];
  logic [3:0][DW-1:0]   dv_rem_r [QB+1];
  logic [3:0][QB-1:0]   dv_q_r   [QB+1];
  logic [RB-1:0]        dv_m_r   [QB+1];
  side_t                dv_sd_r  [QB+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else begin
      dv_v_r[0] <= rd_v_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      dv_rem_r[0][i] <= (DW'(rd_sd_r.nm[i]) << F) + DW'(rd_m_r >> 1);
    end
    dv_q_r[0]  <= '0;
    dv_m_r[0]  <= rd_m_r;
    dv_sd_r[0] <= rd_sd_r;
  end

  // restoring divide, one quotient bit per stage in four lanes
  for (genvar j = 0; j < QB; j++) begin : g_div
    localparam int K = QB - 1 - j;
    logic [DW-1:0] dsub;

    assign dsub = DW'(dv_m_r[j]) << K;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[j+1] <= 1'b0;
      end else begin
        dv_v_r[j+1] <= dv_v_r[j];
      end
    end

    always_ff @(posedge clk) begin
      dv_m_r[j+1]  <= dv_m_r[j];
      dv_sd_r[j+1] <= dv_sd_r[j];
      for (int i = 0; i < 4; i++) begin
        if (dv_rem_r[j][i] >= dsub) begin
          dv_rem_r[j+1][i] <= dv_rem_r[j][i] - dsub;
          dv_q_r[j+1][i]   <= dv_q_r[j][i] | (QB'(1) << K);
        end else begin
          dv_rem_r[j+1][i] <= dv_rem_r[j][i];
          dv_q_r[j+1][i]   <= dv_q_r[j][i];
        end
      end
    end
  end

  // pick the unit normal or the raw normal
  logic                 u_v_r;
  logic signed [UW-1:0] u_u_r [4];
  logic [3:0][W-1:0]    u_a_r;
  logic                 u_lng_r;
  logic signed [UW-1:0] u_sel [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      logic signed [UW-1:0] qv;
      logic [W-1:0]         nraw;
      qv   = UW'(dv_q_r[QB][i]);
      nraw = dv_sd_r[QB].ng[i] ? (~dv_sd_r[QB].nm[i] + W'(1)) : dv_sd_r[QB].nm[i];
      if (dv_sd_r[QB].ng[i]) begin
        qv = -qv;
      end
      u_sel[i] = dv_sd_r[QB].lng ? qv : UW'($signed(nraw));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      u_v_r <= 1'b0;
    end else begin
      u_v_r <= dv_v_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      u_u_r[i] <= u_sel[i];
    end
    u_a_r   <= dv_sd_r[QB].a;
    u_lng_r <= dv_sd_r[QB].lng;
  end

  // dot product terms a * u
  logic                  m_v_r;
  logic signed [PRW-1:0] m_pr_r [4];
  logic signed [UW-1:0]  m_u_r  [4];
  logic [3:0][W-1:0]     m_a_r;
  logic                  m_lng_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
    end else begin
      m_v_r <= u_v_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      m_pr_r[i] <= PRW'($signed(u_a_r[i])) * PRW'(u_u_r[i]);
      m_u_r[i]  <= u_u_r[i];
    end
    m_a_r   <= u_a_r;
    m_lng_r <= u_lng_r;
  end

  // p = round(2 * dot), clamped where the result saturates anyway
  logic                 s_v_r;
  logic signed [CW-1:0] s_p_r;
  logic signed [UW-1:0] s_u_r [4];
  logic [3:0][W-1:0]    s_a_r;
  logic                 s_lng_r;
  logic signed [PW-1:0] s_dot;
  logic signed [PW-1:0] s_p;
  logic signed [PW-1:0] s_pc;
  logic signed [PW-1:0] s_plim;

  always_comb begin
    s_dot = '0;
    for (int i = 0; i < 4; i++) begin
      s_dot = s_dot + PW'(m_pr_r[i]);
    end
    s_p    = (s_dot + (PW'(1) <<< (F - 2))) >>> (F - 1);
    s_plim = PW'(1) <<< (W + F + 1);
    if (s_p > s_plim) begin
      s_pc = s_plim;
    end else if (s_p < -s_plim) begin
      s_pc = -s_plim;
    end else begin
      s_pc = s_p;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_v_r <= 1'b0;
    end else begin
      s_v_r <= m_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s_p_r <= CW'(s_pc);
    for (int i = 0; i < 4; i++) begin
      s_u_r[i] <= m_u_r[i];
    end
    s_a_r   <= m_a_r;
    s_lng_r <= m_lng_r;
  end

  // p * u per lane
  logic                 t_v_r;
  logic signed [MW-1:0] t_prod_r [4];
  logic [3:0][W-1:0]    t_a_r;
  logic                 t_lng_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_v_r <= 1'b0;
    end else begin
      t_v_r <= s_v_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      t_prod_r[i] <= MW'(s_p_r) * MW'(s_u_r[i]);
    end
    t_a_r   <= s_a_r;
    t_lng_r <= s_lng_r;
  end

  // a - round(p * u), saturated
  logic [3:0][W-1:0] f_refl;
  logic [3:0]        f_clip;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      logic signed [MW-1:0] term;
      logic signed [MW:0]   r;
      term = (t_prod_r[i] + (MW'(1) <<< (F - 1))) >>> F;
      r    = (MW + 1)'($signed(t_a_r[i])) - (MW + 1)'(term);
      if (r > RMAX) begin
        f_refl[i] = W'(RMAX);
        f_clip[i] = 1'b1;
      end else if (r < RMIN) begin
        f_refl[i] = W'(RMIN);
        f_clip[i] = 1'b1;
      end else begin
        f_refl[i] = W'(r);
        f_clip[i] = 1'b0;
      end
    end
  end

  // result registers
  logic         out_valid_r;
  logic [W-1:0] out_refl_x_r;
  logic [W-1:0] out_refl_y_r;
  logic [W-1:0] out_refl_z_r;
  logic [W-1:0] out_refl_w_r;
  logic         out_short_r;
  logic         out_clip_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= t_v_r;
    end
  end

  always_ff @(posedge clk) begin
    out_refl_x_r <= f_refl[0];
    out_refl_y_r <= f_refl[1];
    out_refl_z_r <= f_refl[2];
    out_refl_w_r <= f_refl[3];
    out_short_r  <= !t_lng_r;
    out_clip_r   <= |f_clip;
  end

  assign out_valid        = out_valid_r;
  assign out_refl_x       = out_refl_x_r;
  assign out_refl_y       = out_refl_y_r;
  assign out_refl_z       = out_refl_z_r;
  assign out_refl_w       = out_refl_w_r;
  assign out_short_normal = out_short_r;
  assign out_clipped      = out_clip_r;

endmodule

>>> rtl/v4rn_checker.sv
`include "vec4_reflect_about_normal_core_defines.svh"

module v4rn_checker #(
  parameter int COMP_WIDTH = v4rn_pkg::COMP_WIDTH_DEF,
  parameter int FRAC_BITS  = v4rn_pkg::FRAC_BITS_DEF
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic signed [COMP_WIDTH-1:0] in_vec_x,
  input logic signed [COMP_WIDTH-1:0] in_vec_y,
  input logic signed [COMP_WIDTH-1:0] in_vec_z,
  input logic signed [COMP_WIDTH-1:0] in_vec_w,
  input logic signed [COMP_WIDTH-1:0] in_nrm_x,
  input logic signed [COMP_WIDTH-1:0] in_nrm_y,
  input logic signed [COMP_WIDTH-1:0] in_nrm_z,
  input logic signed [COMP_WIDTH-1:0] in_nrm_w,
  input logic                         out_valid,
  input logic signed [COMP_WIDTH-1:0] out_refl_x,
  input logic signed [COMP_WIDTH-1:0] out_refl_y,
  input logic signed [COMP_WIDTH-1:0] out_refl_z,
  input logic signed [COMP_WIDTH-1:0] out_refl_w,
  input logic                         out_short_normal,
  input logic                         out_clipped
);

  localparam int LAT = v4rn_pkg::latency(COMP_WIDTH, FRAC_BITS);

  // every result traces back to a start a fixed latency earlier
  `V4RN_ASSERT_IMP(a_result_has_start, out_valid, $past(start, LAT), "result without start")

  // the pipeline never holds off a transfer
  `V4RN_ASSERT_ALWAYS(a_never_busy, !busy, "busy raised")

  // zero normal passes the vector through unchanged
  `V4RN_ASSERT_IMP(a_zero_normal_pass, out_valid && $past(in_nrm_x == '0 && in_nrm_y == '0 && in_nrm_z == '0 && in_nrm_w == '0, LAT), out_short_normal && !out_clipped && out_refl_x == $past(in_vec_x, LAT) && out_refl_y == $past(in_vec_y, LAT) && out_refl_z == $past(in_vec_z, LAT) && out_refl_w == $past(in_vec_w, LAT), "zero normal not passed through")

endmodule

bind vec4_reflect_about_normal_core v4rn_checker #(
  .COMP_WIDTH(COMP_WIDTH),
  .FRAC_BITS (FRAC_BITS)
) u_v4rn_checker (.*);

>>> tb/sv/vec4_reflect_about_normal_checker.sv
`timescale 1ns / 1ps

module vec4_reflect_about_normal_checker #(
  parameter int CW = v4rn_pkg::COMP_WIDTH_DEF,
  parameter int FB = v4rn_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       busy,
  input  logic signed [CW-1:0]       vec_x,
  input  logic signed [CW-1:0]       vec_y,
  input  logic signed [CW-1:0]       vec_z,
  input  logic signed [CW-1:0]       vec_w,
  input  logic signed [CW-1:0]       nrm_x,
  input  logic signed [CW-1:0]       nrm_y,
  input  logic signed [CW-1:0]       nrm_z,
  input  logic signed [CW-1:0]       nrm_w,
  input  logic                       out_valid,
  input  logic signed [CW-1:0]       refl_x,
  input  logic signed [CW-1:0]       refl_y,
  input  logic signed [CW-1:0]       refl_z,
  input  logic signed [CW-1:0]       refl_w,
  input  logic                       short_normal,
  input  logic                       clipped,
  input  logic                       cfg_we,
  input  logic [v4rn_pkg::CFG_W-1:0] cfg_data,
  output int                         fail_cnt,
  output int                         pending
);

  typedef struct {
    logic signed [CW-1:0] r[4];
    logic                 short_n;
    logic                 clip;
  } refl_t;

  refl_t                      refl_q[$];
  logic [v4rn_pkg::CFG_W-1:0] min_len;

  assign pending = refl_q.size();

  // integer square root, bit by bit
  function automatic longint unsigned int_sqrt(input longint unsigned s);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv >>= 2;
    while (bitv != 0) begin
      if (s >= res + bitv) begin
        s   -= res + bitv;
        res  = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // reflection of a about n, normalized when longer than the threshold, saturated to the component range
  function automatic refl_t reflect(input longint a[4], input longint n[4],
                                    input longint unsigned thr_len);
    refl_t           res;
    longint unsigned s;
    longint unsigned mg;
    longint unsigned q;
    longint          u[4];
    longint          dot;
    longint          p;
    longint          prod;
    longint          term;
    longint          r;
    longint          lim;
    longint          cmax;
    bit              lng;
    s    = 0;
    dot  = 0;
    lim  = longint'(1) << (CW + FB + 1);
    cmax = (longint'(1) << (CW - 1)) - 1;
    res.clip = 1'b0;
    for (int i = 0; i < 4; i++) s += longint'(n[i] * n[i]);
    lng = s > thr_len * thr_len;
    if (lng) begin
      mg = int_sqrt(s);
      if (s - mg * mg > mg) mg++;
      for (int i = 0; i < 4; i++) begin
        q    = (((n[i] < 0 ? -n[i] : n[i]) << FB) + mg / 2) / mg;
        u[i] = n[i] < 0 ? -longint'(q) : longint'(q);
      end
    end else begin
      for (int i = 0; i < 4; i++) u[i] = n[i];
    end
    for (int i = 0; i < 4; i++) dot += a[i] * u[i];
    p = (dot + (longint'(1) << (FB - 2))) >>> (FB - 1);
    for (int i = 0; i < 4; i++) begin
      prod = p * u[i];
      if (prod > lim) prod = lim;
      if (prod < -lim) prod = -lim;
      term = (prod + (longint'(1) << (FB - 1))) >>> FB;
      r    = a[i] - term;
      if (r > cmax) begin
        r = cmax;
        res.clip = 1'b1;
      end else if (r < -cmax - 1) begin
        r = -cmax - 1;
        res.clip = 1'b1;
      end
      res.r[i] = r[CW-1:0];
    end
    res.short_n = !lng;
    return res;
  endfunction

  // predict on each input transfer, compare on each result transfer
  always @(posedge clk) begin
    longint a[4];
    longint n[4];
    refl_t  exp_r;
    refl_t  got;
    int     nbad;
    if (!rst_n) begin
      min_len  <= v4rn_pkg::CFG_RESET;
      fail_cnt <= 0;
      refl_q.delete();
    end else begin
      if (start && !busy) begin
        a = '{longint'(vec_x), longint'(vec_y), longint'(vec_z), longint'(vec_w)};
        n = '{longint'(nrm_x), longint'(nrm_y), longint'(nrm_z), longint'(nrm_w)};
        refl_q.push_back(reflect(a, n, longint'(min_len)));
      end
      if (cfg_we) min_len <= cfg_data;
      if (out_valid) begin
        if (refl_q.size() == 0) begin
          $error("result transfer with nothing expected");
          fail_cnt <= fail_cnt + 1;
        end else begin
          exp_r = refl_q.pop_front();
          got.r = '{refl_x, refl_y, refl_z, refl_w};
          got.short_n = short_normal;
          got.clip = clipped;
          nbad = 0;
          if (got.r[0] !== exp_r.r[0]) begin
            $error("refl_x expected %0d got %0d", exp_r.r[0], got.r[0]);
            nbad++;
          end
          if (got.r[1] !== exp_r.r[1]) begin
            $error("refl_y expected %0d got %0d", exp_r.r[1], got.r[1]);
            nbad++;
          end
          if (got.r[2] !== exp_r.r[2]) begin
            $error("refl_z expected %0d got %0d", exp_r.r[2], got.r[2]);
            nbad++;
          end
          if (got.r[3] !== exp_r.r[3]) begin
            $error("refl_w expected %0d got %0d", exp_r.r[3], got.r[3]);
            nbad++;
          end
          if (got.short_n !== exp_r.short_n) begin
            $error("short_normal expected %0d got %0d", exp_r.short_n, got.short_n);
            nbad++;
          end
          if (got.clip !== exp_r.clip) begin
            $error("clipped expected %0d got %0d", exp_r.clip, got.clip);
            nbad++;
          end
          if (nbad != 0) fail_cnt <= fail_cnt + 1;
        end
      end
    end
  end

endmodule

>>> tb/sv/tb_vec4_reflect_about_normal_core.sv
`timescale 1ns / 1ps

module tb_vec4_reflect_about_normal_core;

  localparam int CW      = v4rn_pkg::COMP_WIDTH_DEF;
  localparam int FB      = v4rn_pkg::FRAC_BITS_DEF;
  localparam int LAT     = v4rn_pkg::latency(CW, FB);
  localparam int N_RAND  = 1450;
  localparam int N_PHASE = 6;
  localparam logic signed [CW-1:0] ONE  = 16'sd4096;
  localparam logic signed [CW-1:0] SMAX = 16'sh7fff;
  localparam logic signed [CW-1:0] SMIN = 16'sh8000;

  logic                       clk;
  logic                       rst_n;
  logic                       start;
  logic                       busy;
  logic signed [CW-1:0]       vx, vy, vz, vw, nx, ny, nz, nw;
  logic                       out_valid;
  logic signed [CW-1:0]       rx, ry, rz, rw;
  logic                       short_normal;
  logic                       clipped;
  logic                       cfg_we;
  logic [v4rn_pkg::CFG_W-1:0] cfg_data;
  int                         fail_cnt;
  int                         pending;

  vec4_reflect_about_normal_core uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_vec_x(vx), .in_vec_y(vy), .in_vec_z(vz), .in_vec_w(vw),
    .in_nrm_x(nx), .in_nrm_y(ny), .in_nrm_z(nz), .in_nrm_w(nw),
    .out_valid(out_valid), .out_refl_x(rx), .out_refl_y(ry), .out_refl_z(rz),
    .out_refl_w(rw), .out_short_normal(short_normal), .out_clipped(clipped),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  vec4_reflect_about_normal_checker chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .vec_x(vx), .vec_y(vy), .vec_z(vz), .vec_w(vw),
    .nrm_x(nx), .nrm_y(ny), .nrm_z(nz), .nrm_w(nw),
    .out_valid(out_valid), .refl_x(rx), .refl_y(ry), .refl_z(rz), .refl_w(rw),
    .short_normal(short_normal), .clipped(clipped),
    .cfg_we(cfg_we), .cfg_data(cfg_data), .fail_cnt(fail_cnt), .pending(pending)
  );

  // clock
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // drive one item and hold it until the transfer
  task automatic send_item(input logic signed [CW-1:0] v[8]);
    start <= 1'b1;
    {vx, vy, vz, vw} <= {v[0], v[1], v[2], v[3]};
    {nx, ny, nz, nw} <= {v[4], v[5], v[6], v[7]};
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_cycles(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // let the pipeline empty, then write the threshold
  task automatic set_threshold(input logic [v4rn_pkg::CFG_W-1:0] val);
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LAT) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= val;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // random component with a mix of full range, small, unit-ish and extreme values
  function automatic logic signed [CW-1:0] rand_comp(input int mode);
    case (mode)
      0: rand_comp = CW'($urandom);
      1: rand_comp = CW'($urandom_range(0, 16) - 8);
      2: rand_comp = CW'($urandom_range(0, 8192) - 4096);
      default: begin
        case ($urandom_range(0, 3))
          0: rand_comp = SMAX;
          1: rand_comp = SMIN;
          2: rand_comp = '0;
          default: rand_comp = CW'($urandom);
        endcase
      end
    endcase
  endfunction

  // stimulus
  initial begin
    logic signed [CW-1:0]       v[8];
    logic [v4rn_pkg::CFG_W-1:0] thr[N_PHASE];
    int                         burst;
    int                         vmode;
    int                         nmode;
    rst_n    = 1'b0;
    start    = 1'b0;
    cfg_we   = 1'b0;
    cfg_data = '0;
    {vx, vy, vz, vw, nx, ny, nz, nw} = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero normal, axis normals, extremes, saturation
    send_item('{ONE, 16'sd2, -16'sd3, SMAX, 0, 0, 0, 0});
    send_item('{ONE, 0, 0, 0, ONE, 0, 0, 0});
    send_item('{ONE, ONE, ONE, ONE, 0, ONE, 0, 0});
    send_item('{ONE, ONE, ONE, ONE, 0, 0, 0, -ONE});
    send_item('{SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, SMAX});
    send_item('{SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, SMIN});
    send_item('{SMAX, SMIN, SMAX, SMIN, SMIN, SMAX, SMIN, SMAX});
    send_item('{SMAX, SMAX, SMAX, SMAX, SMIN, SMIN, SMIN, SMIN});
    send_item('{SMIN, 0, 0, 0, 16'sd1, 0, 0, 0});
    send_item('{SMAX, SMAX, 0, 0, 16'sd1, 16'sd1, 0, 0});
    send_item('{ONE, -ONE, ONE, -ONE, -16'sd1, 0, 0, 0});
    send_item('{-16'sd1, -16'sd1, -16'sd1, -16'sd1, SMIN, 0, 0, 0});
    idle_cycles(3);
    send_item('{16'sd1000, -16'sd2000, 16'sd3000, -16'sd4000, 16'sd3, 16'sd4, 0, 0});

    // short normals against a large threshold, then zero threshold
    set_threshold('1);
    send_item('{ONE, ONE, ONE, ONE, 16'sd20000, 16'sd20000, 0, 0});
    send_item('{SMAX, SMIN, ONE, 0, 16'sd32767, 0, 0, 0});
    send_item('{SMAX, SMAX, SMAX, SMAX, SMIN, 0, 0, 0});
    set_threshold('0);
    send_item('{ONE, ONE, ONE, ONE, 0, 0, 0, 0});
    send_item('{ONE, ONE, ONE, ONE, 0, 0, 16'sd1, 0});

    // random phases over several thresholds, extremes included
    thr = '{15'd0, 15'd1, 15'h7fff, 15'd4096, 15'd8, 15'($urandom)};
    for (int ph = 0; ph < N_PHASE; ph++) begin
      set_threshold(thr[ph]);
      for (int k = 0; k < N_RAND / N_PHASE; k += burst) begin
        burst = $urandom_range(1, 24);
        vmode = $urandom_range(0, 3);
        nmode = $urandom_range(0, 3);
        for (int j = 0; j < burst; j++) begin
          for (int c = 0; c < 4; c++) v[c] = rand_comp(vmode);
          for (int c = 4; c < 8; c++) v[c] = rand_comp(nmode);
          send_item(v);
        end
        if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 6));
      end
    end

    // drain and verdict
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LAT + 10) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/v4rn_pkg.sv
rtl/vec4_reflect_about_normal_core.sv
rtl/v4rn_checker.sv
tb/sv/vec4_reflect_about_normal_checker.sv
tb/sv/tb_vec4_reflect_about_normal_core.sv
